[hw/rtl/bclp_pkg.sv]
`default_nettype none

package bclp_pkg;

    localparam int CFG_W = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd500;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 16'd500;
    localparam logic             POWER_RST       = 1'b0;
    localparam logic             LEVEL_RELEASED  = 1'b1;

    localparam logic [1:0] CLICK_MAX   = 2'd3;
    localparam logic [1:0] PAIR_CLICKS = 2'd2;
    localparam logic [1:0] ONE_CLICK   = 2'd1;

    typedef enum logic [1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_DOUBLE_CLICK = 2'd1,
        REG_LONG_PRESS   = 2'd2,
        REG_POWER_INIT   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] double_click_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic             power_load;
        logic             power_value;
    } cfg_t;

    typedef struct packed {
        logic pair_pulse;
        logic power_toggle;
        logic power_on;
        logic pressed;
    } res_t;

endpackage

`default_nettype wire

[hw/rtl/bclp_if.sv]
`default_nettype none

interface bclp_in_if;
    logic        valid;
    logic        ready;
    logic        button_level;
    logic [31:0] now_ms;

    modport source (output valid, output button_level, output now_ms, input ready);
    modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

interface bclp_out_if;
    logic valid;
    logic ready;
    logic pair_pulse;
    logic power_toggle;
    logic power_on;
    logic pressed;

    modport source (output valid, output pair_pulse, output power_toggle,
                    output power_on, output pressed, input ready);
    modport sink   (input valid, input pair_pulse, input power_toggle,
                    input power_on, input pressed, output ready);
endinterface

`default_nettype wire

[hw/rtl/bclp_cfg.sv]
`default_nettype none

module bclp_cfg
    import bclp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [CFG_W-1:0] debounce_reg, debounce_next;
    logic [CFG_W-1:0] dbl_reg, dbl_next;
    logic [CFG_W-1:0] long_reg, long_next;
    logic             power_load;

    always_comb
    begin
        debounce_next = debounce_reg;
        dbl_next      = dbl_reg;
        long_next     = long_reg;
        power_load    = 1'b0;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DEBOUNCE:     debounce_next = cfg_data;
                REG_DOUBLE_CLICK: dbl_next      = cfg_data;
                REG_LONG_PRESS:   long_next     = cfg_data;
                REG_POWER_INIT:   power_load    = 1'b1;
                default:          power_load    = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            dbl_reg      <= DOUBLE_CLICK_RST;
            long_reg     <= LONG_PRESS_RST;
        end
        else
        begin
            debounce_reg <= debounce_next;
            dbl_reg      <= dbl_next;
            long_reg     <= long_next;
        end
    end

    // power restore takes effect at the write edge itself
    assign cfg.debounce_ms     = debounce_reg;
    assign cfg.double_click_ms = dbl_reg;
    assign cfg.long_press_ms   = long_reg;
    assign cfg.power_load      = power_load;
    assign cfg.power_value     = cfg_data[0];

endmodule

`default_nettype wire

[hw/rtl/bclp_core.sv]
`default_nettype none

module bclp_core
    import bclp_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  level,
    input  wire logic [TIME_WIDTH-1:0] now,
    input  wire cfg_t                  cfg,
    output res_t                       res
);

    logic                  stable_reg, stable_next;
    logic [TIME_WIDTH-1:0] change_reg, change_next;
    logic [TIME_WIDTH-1:0] first_reg, first_next;
    logic [TIME_WIDTH-1:0] last_reg, last_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  held_reg, held_next;
    logic                  ldone_reg, ldone_next;
    logic                  power_reg, power_next;

    logic [TIME_WIDTH-1:0] deb_thr, dbl_thr, long_thr;
    logic [TIME_WIDTH-1:0] el_chg, el_last, el_pair;
    logic                  accept, press, release_evt;
    logic [1:0]            cnt_inc;
    logic                  eval, pair, toggle, ldone_mid;

    assign deb_thr  = TIME_WIDTH'(cfg.debounce_ms);
    assign dbl_thr  = TIME_WIDTH'(cfg.double_click_ms);
    assign long_thr = TIME_WIDTH'(cfg.long_press_ms);

    // all differences wrap at TIME_WIDTH bits
    assign el_chg  = now - change_reg;
    assign el_last = now - last_reg;
    assign el_pair = last_reg - first_reg;

    always_comb
    begin
        accept      = (el_chg > deb_thr) && (level != stable_reg);
        press       = accept && !level;
        release_evt = accept && level;

        cnt_inc = cnt_reg;
        if (press && cnt_reg != CLICK_MAX)
            cnt_inc = cnt_reg + 2'd1;

        first_next  = (press && cnt_inc == ONE_CLICK) ? now : first_reg;
        last_next   = press ? now : last_reg;
        change_next = accept ? now : change_reg;
        stable_next = accept ? level : stable_reg;

        // a fresh press makes the time since the last click zero
        eval = !press && (cnt_inc != 2'd0) && (el_last > dbl_thr);
        pair = eval && (cnt_inc == PAIR_CLICKS) && (el_pair <= dbl_thr);
        cnt_next = eval ? 2'd0 : cnt_inc;

        held_next = press ? 1'b1 : (release_evt ? 1'b0 : held_reg);
        ldone_mid = press ? 1'b0 : ldone_reg;

        toggle     = held_next && !ldone_mid && !accept && (el_chg > long_thr);
        power_next = power_reg ^ toggle;
        ldone_next = ldone_mid | toggle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= LEVEL_RELEASED;
            change_reg <= '0;
            first_reg  <= '0;
            last_reg   <= '0;
            cnt_reg    <= '0;
            held_reg   <= 1'b0;
            ldone_reg  <= 1'b0;
            power_reg  <= POWER_RST;
        end
        else
        begin
            if (adv)
            begin
                stable_reg <= stable_next;
                change_reg <= change_next;
                first_reg  <= first_next;
                last_reg   <= last_next;
                cnt_reg    <= cnt_next;
                held_reg   <= held_next;
                ldone_reg  <= ldone_next;
            end
            if (cfg.power_load)
                power_reg <= cfg.power_value;
            else if (adv)
                power_reg <= power_next;
        end
    end

    assign res.pair_pulse   = pair;
    assign res.power_toggle = toggle;
    assign res.power_on     = power_next;
    assign res.pressed      = held_next;

    a_pair_clears: assert property (@(posedge clk) disable iff (!rst_n)
        adv && pair |=> cnt_reg == 2'd0)
        else $error("click count not cleared after pair pulse");

    a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
        adv && toggle && !cfg.power_load |=> power_reg != $past(power_reg))
        else $error("power bit did not flip on long press");

    a_ldone_held: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ldone_reg) |-> held_reg)
        else $error("long press marked while not held");

    a_change_level: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(change_reg) |-> !$stable(stable_reg))
        else $error("change time moved without a level change");

endmodule

`default_nettype wire

[hw/rtl/button_click_long_press_detector_top.sv]
// A word waits in the input stage until the output stage is free or read; its result
// is then registered there. Throughput: one sample word per cycle unless back-pressured;
// state updates in the same cycle the sample is evaluated, so the next one sees it.
// Reset (rst_n low, async): config back to 50/500/500 ms, power off, button released,
// click count and timers cleared, both stages empty.
`default_nettype none

module button_click_long_press_detector_top
    import bclp_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    bclp_in_if.sink               sample,
    bclp_out_if.source            result,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t res;

    logic                  in_vld_reg, in_vld_next;
    logic                  in_level_reg;
    logic [TIME_WIDTH-1:0] in_now_reg;
    logic                  out_vld_reg, out_vld_next;
    res_t                  out_reg;
    logic                  adv, take;

    assign adv  = in_vld_reg && (!out_vld_reg || result.ready);
    assign take = sample.valid && sample.ready;
    assign sample.ready = !in_vld_reg || adv;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
            in_vld_next = 1'b1;
        else if (adv)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (adv)
            out_vld_next = 1'b1;
        else if (result.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_level_reg <= sample.button_level;
            in_now_reg   <= TIME_WIDTH'(sample.now_ms);
        end
        if (adv)
            out_reg <= res;
    end

    bclp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bclp_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .level (in_level_reg),
        .now   (in_now_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign result.valid        = out_vld_reg;
    assign result.pair_pulse   = out_reg.pair_pulse;
    assign result.power_toggle = out_reg.power_toggle;
    assign result.power_on     = out_reg.power_on;
    assign result.pressed      = out_reg.pressed;

endmodule

`default_nettype wire

[tb/tb_button_click_long_press_detector_top.sv]
`timescale 1ns / 100ps

module tb_button_click_long_press_detector_top;
    import bclp_pkg::*;

    localparam int   CYCLE_LIMIT   = 300000;
    localparam logic LEVEL_PRESSED = ~LEVEL_RELEASED;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    bclp_in_if  sample_if();
    bclp_out_if result_if();

    button_click_long_press_detector_top #(
        .TIME_WIDTH (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // detector model state and its copy of the registers
    logic             stable_lvl;
    logic [31:0]      chg_ms;
    logic [31:0]      first_click_ms;
    logic [31:0]      last_click_ms;
    logic [1:0]       clicks;
    logic             held_m;
    logic             long_m;
    logic             power_m;
    logic [CFG_W-1:0] deb_cfg;
    logic [CFG_W-1:0] dbl_cfg;
    logic [CFG_W-1:0] lp_cfg;

    res_t        exp_button_q[$];
    int          mismatches = 0;
    int          words_sent = 0;
    bit          quiet_tail = 1'b0;
    int          stall_left = 0;
    logic [31:0] gen_ms     = '0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic predict_button(input logic lvl, input logic [31:0] now);
        logic [31:0] since_change;
        logic [31:0] since_click;
        logic [31:0] click_span;
        res_t        word;
        word = '0;
        since_change = now - chg_ms;
        if (since_change > {16'd0, deb_cfg} && lvl != stable_lvl)
        begin
            chg_ms     = now;
            stable_lvl = lvl;
            if (lvl == LEVEL_PRESSED)
            begin
                held_m = 1'b1;
                long_m = 1'b0;
                if (clicks < CLICK_MAX)
                    clicks = clicks + 2'd1;
                if (clicks == ONE_CLICK)
                    first_click_ms = now;
                last_click_ms = now;
            end
            else
                held_m = 1'b0;
        end
        since_click = now - last_click_ms;
        click_span  = last_click_ms - first_click_ms;
        if (clicks != '0 && since_click > {16'd0, dbl_cfg})
        begin
            if (clicks == PAIR_CLICKS && click_span <= {16'd0, dbl_cfg})
                word.pair_pulse = 1'b1;
            clicks = '0;
        end
        since_change = now - chg_ms;
        if (held_m && !long_m && since_change > {16'd0, lp_cfg})
        begin
            power_m           = ~power_m;
            long_m            = 1'b1;
            word.power_toggle = 1'b1;
        end
        word.power_on = power_m;
        word.pressed  = held_m;
        exp_button_q.push_back(word);
    endtask

    task automatic report_mismatch(input string what, input res_t want, input res_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch at %0t (%s): expected pair=%b toggle=%b power=%b pressed=%b,",
                      " got pair=%b toggle=%b power=%b pressed=%b"},
                     $realtime, what, want.pair_pulse, want.power_toggle, want.power_on,
                     want.pressed, got.pair_pulse, got.power_toggle, got.power_on, got.pressed);
    endtask

    // result side: check each accepted word against the oldest prediction
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got.pair_pulse   = result_if.pair_pulse;
            got.power_toggle = result_if.power_toggle;
            got.power_on     = result_if.power_on;
            got.pressed      = result_if.pressed;
            if (exp_button_q.size() == 0)
                report_mismatch("no word expected", '0, got);
            else
            begin
                want = exp_button_q.pop_front();
                if (got.pair_pulse !== want.pair_pulse || got.power_toggle !== want.power_toggle
                    || got.power_on !== want.power_on || got.pressed !== want.pressed)
                    report_mismatch("field", want, got);
            end
        end
    end

    // result side back-pressure in random bursts, always ready once quiet_tail is set
    initial
    begin
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (quiet_tail)
                result_if.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if ($urandom_range(9, 0) == 0)
            begin
                stall_left = $urandom_range(13, 1) - 1;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic lvl, input logic [31:0] t);
        int gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(7, 0) == 0)
            gap = $urandom_range(13, 1);
        if (gap > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.button_level <= lvl;
        sample_if.now_ms       <= t;
        do
        begin
            @(posedge clk);
        end
        while (!sample_if.ready);
        predict_button(lvl, t);
        words_sent++;
    endtask

    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (exp_button_q.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_DEBOUNCE:     deb_cfg = val;
            REG_DOUBLE_CLICK: dbl_cfg = val;
            REG_LONG_PRESS:   lp_cfg  = val;
            REG_POWER_INIT:   power_m = val[0];
            default: ;
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] dbl,
                                  input logic [CFG_W-1:0] lp, input logic pwr);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_DOUBLE_CLICK, dbl);
        write_reg(REG_LONG_PRESS, lp);
        // upper bits are don't-care for the power restore
        write_reg(REG_POWER_INIT, {15'($urandom()), pwr});
    endtask

    function automatic logic [CFG_W-1:0] pick_threshold();
        case ($urandom_range(3, 0))
            0:       return CFG_W'($urandom_range(16, 0));
            1:       return CFG_W'($urandom_range(400, 17));
            2:       return CFG_W'($urandom_range(3000, 401));
            default: return CFG_W'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] jitter(input logic [31:0] span);
        return $urandom_range(span, 0);
    endfunction

    task automatic emit(input logic lvl, input logic [31:0] t);
        gen_ms = t;
        send_sample(lvl, t);
    endtask

    // move time forward to target, never backwards
    task automatic step_to(input logic lvl, input logic [31:0] target);
        logic [31:0] ahead;
        ahead = target - gen_ms;
        if (ahead[31])
            target = gen_ms + 32'd1;
        emit(lvl, target);
    endtask

    task automatic hold(input logic lvl, input int n, input logic [31:0] span);
        repeat (n) emit(lvl, gen_ms + jitter(span));
    endtask

    // level change just past the debounce, sometimes probing the exact boundary first
    task automatic change_level(input logic lvl, input logic [31:0] thr);
        logic [31:0] base;
        base = chg_ms;
        if ($urandom_range(3, 0) == 0)
            step_to(lvl, base + thr);
        step_to(lvl, base + thr + 32'd1
                     + (($urandom_range(1, 0) == 0) ? 32'd0 : jitter(thr / 2 + 4)));
    endtask

    task automatic settle_window();
        if ($urandom_range(2, 0) == 0)
            step_to(LEVEL_RELEASED, last_click_ms + dbl_cfg);
        step_to(LEVEL_RELEASED, last_click_ms + dbl_cfg + 32'd1
                                + (($urandom_range(1, 0) == 0) ? 32'd0 : jitter(dbl_cfg / 4 + 4)));
    endtask

    task automatic short_click();
        change_level(LEVEL_PRESSED, 32'(deb_cfg));
        hold(LEVEL_PRESSED, $urandom_range(2, 0), lp_cfg / 4 + 1);
        change_level(LEVEL_RELEASED, 32'(deb_cfg));
    endtask

    task automatic click_burst(input int n);
        repeat (n) short_click();
        settle_window();
    endtask

    task automatic run_gestures(input int count);
        int stop_at;
        int pick;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 12)
                click_burst(1);
            else if (pick < 38)
                click_burst(2);
            else if (pick < 48)
                click_burst($urandom_range(4, 3));
            else if (pick < 54)
            begin
                // second press after a silent gap: window already exceeded
                short_click();
                step_to(LEVEL_PRESSED, last_click_ms + dbl_cfg + 32'd1 + jitter(dbl_cfg + 4));
                change_level(LEVEL_RELEASED, 32'(deb_cfg));
                settle_window();
            end
            else if (pick < 72)
            begin
                change_level(LEVEL_PRESSED, 32'(deb_cfg));
                hold(LEVEL_PRESSED, $urandom_range(1, 0), lp_cfg / 4 + 1);
                if ($urandom_range(2, 0) == 0)
                    step_to(LEVEL_PRESSED, chg_ms + lp_cfg);
                step_to(LEVEL_PRESSED, chg_ms + lp_cfg + 32'd1 + jitter(lp_cfg / 8 + 2));
                hold(LEVEL_PRESSED, $urandom_range(2, 0), lp_cfg + 4);
                change_level(LEVEL_RELEASED, 32'(deb_cfg));
            end
            else if (pick < 86)
            begin
                // contact bounce, each sample within the debounce interval of the one before
                repeat ($urandom_range(6, 2))
                    emit(1'($urandom_range(1, 0)), gen_ms + jitter(32'(deb_cfg)));
            end
            else if (pick < 92)
                emit(1'($urandom_range(1, 0)), $urandom());
            else
                emit(1'($urandom_range(1, 0)),
                     gen_ms + jitter(32'd2 * deb_cfg + dbl_cfg + lp_cfg + 2));
        end
    endtask

    task automatic test_directed_defaults();
        emit(LEVEL_PRESSED, 32'd10);      // inside debounce from reset
        emit(LEVEL_PRESSED, 32'd51);      // first click
        emit(LEVEL_RELEASED, 32'd60);     // bounce
        emit(LEVEL_RELEASED, 32'd101);    // exactly on debounce, rejected
        emit(LEVEL_RELEASED, 32'd102);
        emit(LEVEL_PRESSED, 32'd160);     // second click
        emit(LEVEL_RELEASED, 32'd220);
        emit(LEVEL_RELEASED, 32'd660);    // exactly on window, no evaluation
        emit(LEVEL_RELEASED, 32'd661);    // pair
        emit(LEVEL_PRESSED, 32'd800);
        emit(LEVEL_PRESSED, 32'd1300);    // exactly long-press time
        emit(LEVEL_PRESSED, 32'd1301);    // toggle, single click dropped
        emit(LEVEL_PRESSED, 32'd1900);    // no second toggle in one press
        emit(LEVEL_RELEASED, 32'd2000);
        emit(LEVEL_PRESSED, 32'd2100);
        emit(LEVEL_RELEASED, 32'd2160);
        emit(LEVEL_PRESSED, 32'd2220);
        emit(LEVEL_RELEASED, 32'd2280);
        emit(LEVEL_PRESSED, 32'd2340);
        emit(LEVEL_RELEASED, 32'd2400);
        emit(LEVEL_PRESSED, 32'd2460);    // count saturates
        emit(LEVEL_RELEASED, 32'd2520);
        emit(LEVEL_RELEASED, 32'd3100);   // three or more: no pair
        emit(LEVEL_PRESSED, 32'hFFFF_FFF0);
        emit(LEVEL_RELEASED, 32'h0000_0020); // wrapped, still inside debounce
        emit(LEVEL_RELEASED, 32'h0000_0040);
        emit(LEVEL_PRESSED, 32'h0000_0800);  // late second click
        emit(LEVEL_RELEASED, 32'h0000_0900);
        emit(LEVEL_RELEASED, 32'h0000_0C00); // clicks too far apart: no pair
    endtask

    task automatic test_zero_thresholds();
        set_thresholds('0, '0, '0, 1'b1);
        run_gestures(180);
    endtask

    task automatic test_max_thresholds();
        set_thresholds('1, '1, '1, 1'b0);
        run_gestures(180);
    endtask

    task automatic test_random_thresholds();
        repeat (4)
        begin
            set_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                           1'($urandom_range(1, 0)));
            run_gestures(170);
        end
    endtask

    task automatic test_quiet_tail();
        set_thresholds(DEBOUNCE_RST, DOUBLE_CLICK_RST, LONG_PRESS_RST,
                       1'($urandom_range(1, 0)));
        quiet_tail = 1'b1;
        run_gestures(250);
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= REG_DEBOUNCE;
        cfg_data               <= '0;
        sample_if.valid        <= 1'b0;
        sample_if.button_level <= LEVEL_RELEASED;
        sample_if.now_ms       <= '0;
        deb_cfg        = DEBOUNCE_RST;
        dbl_cfg        = DOUBLE_CLICK_RST;
        lp_cfg         = LONG_PRESS_RST;
        power_m        = POWER_RST;
        stable_lvl     = LEVEL_RELEASED;
        chg_ms         = '0;
        first_click_ms = '0;
        last_click_ms  = '0;
        clicks         = '0;
        held_m         = 1'b0;
        long_m         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_defaults();
        test_zero_thresholds();
        test_max_thresholds();
        test_random_thresholds();
        test_quiet_tail();

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
